### sv/sorted_static_linked_list_core_defines.svh
// Assertion macros for the sorted linked list core.
// Included by the top level; depends on nothing else.
`ifndef SORTED_STATIC_LINKED_LIST_CORE_DEFINES_SVH
`define SORTED_STATIC_LINKED_LIST_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLL_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLL_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sll_pkg.sv
// Shared constants, codes and memory request types for the sorted linked list core.
// Used by the engine and the top level; depends on nothing.
package sll_pkg;

    localparam int ENTRIES = 64;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int LINK_W  = $clog2(ENTRIES + 1);
    // The invalid link is coded as the slot count itself.
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(ENTRIES);

    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_COUNT  = 2'd2,
        MODE_REINIT = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_DUP     = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    // Request to the key and payload memories (shared addresses).
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
        logic [ADDR_W-1:0] rd_addr;
    } ent_req_t;

    // Request to the link memory.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [LINK_W-1:0] wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } link_req_t;

endpackage

### sv/sorted_static_linked_list_core.sv
// Sorted linked list core: 64 slots chained in ascending signed key order, with a
// free list of unused slots. Each transaction on the s_ channel is one operation
// (insert, delete, count, reinitialize) and yields exactly one m_ transaction with
// status, slot and entry count. Items are handled one at a time. Insert and delete
// walk the list one entry per cycle through the single read port of the link
// memory; an insert into a full list is answered without a walk. After the walk,
// any relinking is written and the result is registered, and only then is the
// next transaction accepted. Count does no walk. After reset, and for every
// reinitialize, a clearing pass rebuilds the link chain one entry per cycle,
// during which no transaction is accepted; a reinitialize result follows the
// clearing pass. A finished result waits in an output register and the next
// operation can be accepted while it waits.
// Depends on sll_pkg, sll_engine, sll_ram and the assertion macro header.
`include "sorted_static_linked_list_core_defines.svh"

module sorted_static_linked_list_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic signed [31:0] s_key,
    input  logic [31:0]        s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [5:0]         m_slot,
    output logic [6:0]         m_count
);
    import sll_pkg::*;

    ent_req_t          ent_req;
    link_req_t         link_req;
    logic [KEY_W-1:0]  key_rd;
    logic [LINK_W-1:0] link_rd;

    sll_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_key     (s_key),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_slot    (m_slot),
        .m_count   (m_count),
        .ent_req   (ent_req),
        .link_req  (link_req),
        .key_rd    (key_rd),
        .link_rd   (link_rd)
    );

    sll_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ent_req.wr_en),
        .wr_addr (ent_req.wr_addr),
        .wr_data (ent_req.key),
        .rd_addr (ent_req.rd_addr),
        .rd_data (key_rd)
    );

    // Payloads are stored with their keys and never read back by the operations.
    sll_ram #(.WIDTH(PAY_W), .DEPTH(ENTRIES)) u_pay_ram (
        .aclk    (aclk),
        .wr_en   (ent_req.wr_en),
        .wr_addr (ent_req.wr_addr),
        .wr_data (ent_req.payload),
        .rd_addr (ent_req.rd_addr),
        .rd_data ()
    );

    sll_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_req.wr_en),
        .wr_addr (link_req.wr_addr),
        .wr_data (link_req.wr_data),
        .rd_addr (link_req.rd_addr),
        .rd_data (link_rd)
    );

    `SLL_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready,
                    "operation accepted while another was in progress")
    `SLL_ASSERT_IMP(a_slot_zero_on_fail, aclk, aresetn, m_valid && (m_status != ST_OK),
                    m_slot == '0, "failed operation reports a nonzero slot")
    `SLL_ASSERT_IMP(a_full_count, aclk, aresetn, m_valid && (m_status == ST_FULL),
                    m_count == COUNT_W'(ENTRIES), "list full reported with free slots left")
    `SLL_ASSERT_IMP(a_no_link_write_idle, aclk, aresetn, s_ready,
                    !link_req.wr_en && !ent_req.wr_en, "memory written while idle")

endmodule

### sv/sll_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the key, payload and link stores.
module sll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/sll_engine.sv
// Operation sequencer of the sorted linked list: list walk, relinking, free list,
// link-memory clearing pass and result register. Depends on sll_pkg.
module sll_engine (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_mode,
    input  logic signed [31:0]        s_key,
    input  logic [31:0]               s_payload,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic [5:0]                m_slot,
    output logic [6:0]                m_count,
    output sll_pkg::ent_req_t         ent_req,
    output sll_pkg::link_req_t        link_req,
    input  logic [sll_pkg::KEY_W-1:0] key_rd,
    input  logic [sll_pkg::LINK_W-1:0] link_rd
);
    import sll_pkg::*;

    typedef enum logic [6:0] {
        S_INIT = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_WALK = 7'b0000100,
        S_INS  = 7'b0001000,
        S_LINK = 7'b0010000,
        S_FREE = 7'b0100000,
        S_RESP = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [PAY_W-1:0]   pay_reg, pay_next;
    logic [LINK_W-1:0]  cur_reg, cur_next;
    logic [LINK_W-1:0]  prev_reg, prev_next;
    logic [LINK_W-1:0]  list_head_reg, list_head_next;
    logic [LINK_W-1:0]  free_head_reg, free_head_next;
    logic [LINK_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0]  init_idx_reg, init_idx_next;
    logic               reinit_reg, reinit_next;
    status_t            pend_status_reg, pend_status_next;
    logic [ADDR_W-1:0]  pend_slot_reg, pend_slot_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [5:0]         m_slot_reg, m_slot_next;
    logic [6:0]         m_count_reg, m_count_next;

    logic cur_is_slot;
    logic prev_is_slot;
    logic key_below;
    logic key_equal;

    assign cur_is_slot  = (cur_reg < NIL_LINK);
    assign prev_is_slot = (prev_reg < NIL_LINK);
    assign key_below    = ($signed(key_rd) < $signed(key_reg));
    assign key_equal    = (key_rd == key_reg);

    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        key_next         = key_reg;
        pay_next         = pay_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        list_head_next   = list_head_reg;
        free_head_next   = free_head_reg;
        count_next       = count_reg;
        init_idx_next    = init_idx_reg;
        reinit_next      = reinit_reg;
        pend_status_next = pend_status_reg;
        pend_slot_next   = pend_slot_reg;
        m_status_next    = m_status_reg;
        m_slot_next      = m_slot_reg;
        m_count_next     = m_count_reg;
        m_valid_next     = m_valid_reg && !m_ready;

        ent_req          = '0;
        ent_req.wr_addr  = free_head_reg[ADDR_W-1:0];
        ent_req.key      = key_reg;
        ent_req.payload  = pay_reg;
        ent_req.rd_addr  = cur_reg[ADDR_W-1:0];
        link_req         = '0;
        link_req.rd_addr = cur_reg[ADDR_W-1:0];
        s_ready          = 1'b0;

        unique case (state_reg)
            S_INIT: begin
                // One link entry per cycle; the last slot gets the invalid link.
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = init_idx_reg;
                link_req.wr_data = LINK_W'(init_idx_reg) + LINK_W'(1);
                init_idx_next    = init_idx_reg + ADDR_W'(1);
                if (init_idx_reg == ADDR_W'(ENTRIES - 1)) begin
                    init_idx_next    = '0;
                    list_head_next   = NIL_LINK;
                    free_head_next   = '0;
                    count_next       = '0;
                    pend_status_next = ST_OK;
                    pend_slot_next   = '0;
                    state_next       = reinit_reg ? S_RESP : S_IDLE;
                    reinit_next      = 1'b0;
                end
            end
            S_IDLE: begin
                s_ready          = 1'b1;
                // Start the walk read at the list head in the accept cycle.
                ent_req.rd_addr  = list_head_reg[ADDR_W-1:0];
                link_req.rd_addr = list_head_reg[ADDR_W-1:0];
                if (s_valid) begin
                    mode_next        = mode_t'(s_mode);
                    key_next         = s_key;
                    pay_next         = s_payload;
                    cur_next         = list_head_reg;
                    prev_next        = NIL_LINK;
                    pend_status_next = ST_OK;
                    pend_slot_next   = '0;
                    case (mode_t'(s_mode))
                        MODE_INSERT: begin
                            if (free_head_reg < NIL_LINK) begin
                                state_next = S_WALK;
                            end else begin
                                pend_status_next = ST_FULL;
                                state_next       = S_RESP;
                            end
                        end
                        MODE_DELETE: begin
                            state_next = S_WALK;
                        end
                        MODE_REINIT: begin
                            reinit_next = 1'b1;
                            state_next  = S_INIT;
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // Memory outputs hold the key and link of the current slot.
                if (cur_is_slot && key_below) begin
                    prev_next        = cur_reg;
                    cur_next         = link_rd;
                    ent_req.rd_addr  = link_rd[ADDR_W-1:0];
                    link_req.rd_addr = link_rd[ADDR_W-1:0];
                end else if (mode_reg == MODE_INSERT) begin
                    if (cur_is_slot && key_equal) begin
                        pend_status_next = ST_DUP;
                        state_next       = S_RESP;
                    end else begin
                        // Fetch the link of the free head to advance the free list.
                        link_req.rd_addr = free_head_reg[ADDR_W-1:0];
                        state_next       = S_INS;
                    end
                end else begin
                    if (cur_is_slot && key_equal) begin
                        if (prev_is_slot) begin
                            link_req.wr_en   = 1'b1;
                            link_req.wr_addr = prev_reg[ADDR_W-1:0];
                            link_req.wr_data = link_rd;
                        end else begin
                            list_head_next = link_rd;
                        end
                        pend_slot_next = cur_reg[ADDR_W-1:0];
                        state_next     = S_FREE;
                    end else begin
                        pend_status_next = ST_MISSING;
                        state_next       = S_RESP;
                    end
                end
            end
            S_INS: begin
                ent_req.wr_en    = 1'b1;
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = free_head_reg[ADDR_W-1:0];
                link_req.wr_data = cur_reg;
                free_head_next   = link_rd;
                pend_slot_next   = free_head_reg[ADDR_W-1:0];
                if (prev_is_slot) begin
                    state_next = S_LINK;
                end else begin
                    list_head_next = free_head_reg;
                    count_next     = count_reg + LINK_W'(1);
                    state_next     = S_RESP;
                end
            end
            S_LINK: begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = prev_reg[ADDR_W-1:0];
                link_req.wr_data = LINK_W'(pend_slot_reg);
                count_next       = count_reg + LINK_W'(1);
                state_next       = S_RESP;
            end
            S_FREE: begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = cur_reg[ADDR_W-1:0];
                link_req.wr_data = free_head_reg;
                free_head_next   = cur_reg;
                if (count_reg != '0) begin
                    count_next = count_reg - LINK_W'(1);
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = pend_status_reg;
                    m_slot_next   = SLOT_W'(pend_slot_reg);
                    m_count_next  = COUNT_W'(count_reg);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            init_idx_reg  <= '0;
            reinit_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            list_head_reg <= NIL_LINK;
            free_head_reg <= '0;
            count_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            init_idx_reg  <= init_idx_next;
            reinit_reg    <= reinit_next;
            m_valid_reg   <= m_valid_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg        <= mode_next;
        key_reg         <= key_next;
        pay_reg         <= pay_next;
        cur_reg         <= cur_next;
        prev_reg        <= prev_next;
        pend_status_reg <= pend_status_next;
        pend_slot_reg   <= pend_slot_next;
        m_status_reg    <= m_status_next;
        m_slot_reg      <= m_slot_next;
        m_count_reg     <= m_count_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;
    assign m_count  = m_count_reg;

endmodule

### tb/sorted_static_linked_list_core_tb.sv
// Self-checking testbench for sorted_static_linked_list_core: directed table, then random
// insert/delete/count/reinitialize traffic checked against an in-bench list predictor.
// Depends on sll_pkg and the core RTL only.
`timescale 1ns / 1ps

module sorted_static_linked_list_core_tb;
    import sll_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int KEY_POOL    = 96;
    localparam int RAND_BLOCKS = 15;
    localparam int BLOCK_ITEMS = 100;

    typedef struct {
        status_t    status;
        logic [5:0] slot;
        logic [6:0] count;
    } outcome_t;

    typedef struct {
        mode_t             mode;
        logic signed [31:0] key;
        logic [31:0]       payload;
        bit                typed;
        outcome_t          want;
    } plan_row_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_mode;
    logic signed [31:0] s_key;
    logic [31:0]        s_payload;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_status;
    logic [5:0]         m_slot;
    logic [6:0]         m_count;

    sorted_static_linked_list_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_key     (s_key),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_slot    (m_slot),
        .m_count   (m_count)
    );

    always #6 aclk = ~aclk;

    // Shadow copy of the list: key and payload stores, links, heads and occupancy.
    logic signed [31:0] list_key  [ENTRIES];
    logic [31:0]        list_pay  [ENTRIES];
    int                 list_next [ENTRIES];
    int                 list_head;
    int                 free_head;
    int                 occupancy;
    int                 peak_occupancy;

    outcome_t           pending_results [$];
    logic signed [31:0] key_pool [KEY_POOL];
    plan_row_t          plan [$];

    bit  quiet;
    int  errors;
    int  cycles;
    int  issued;
    int  n_full, n_dup, n_missing;

    function automatic void rebuild_chain();
        for (int i = 0; i < ENTRIES; i++) begin
            list_next[i] = i + 1;
        end
        list_head = ENTRIES;
        free_head = 0;
        occupancy = 0;
    endfunction

    // Finds the first entry whose key is not below k, and the entry before it.
    function automatic void find_position(input logic signed [31:0] k,
                                          output int prev, output int cur);
        int steps;
        prev  = ENTRIES;
        cur   = list_head;
        steps = 0;
        while (cur < ENTRIES && steps < ENTRIES && list_key[cur] < k) begin
            prev = cur;
            cur  = list_next[cur];
            steps++;
        end
        if (cur >= ENTRIES) cur = ENTRIES;
    endfunction

    function automatic outcome_t apply_list_op(input mode_t md, input logic signed [31:0] k,
                                               input logic [31:0] p);
        outcome_t res;
        int prev, cur, s;
        res.status = ST_OK;
        res.slot   = '0;
        case (md)
            MODE_INSERT: begin
                if (free_head >= ENTRIES) begin
                    res.status = ST_FULL;
                end else begin
                    find_position(k, prev, cur);
                    if (cur < ENTRIES && list_key[cur] == k) begin
                        res.status = ST_DUP;
                    end else begin
                        s = free_head;
                        free_head = list_next[s];
                        list_key[s] = k;
                        list_pay[s] = p;
                        if (prev < ENTRIES) begin
                            list_next[s]    = list_next[prev];
                            list_next[prev] = s;
                        end else begin
                            list_next[s] = list_head;
                            list_head    = s;
                        end
                        occupancy++;
                        res.slot = 6'(s);
                    end
                end
            end
            MODE_DELETE: begin
                find_position(k, prev, cur);
                if (cur >= ENTRIES || list_key[cur] != k) begin
                    res.status = ST_MISSING;
                end else begin
                    if (prev < ENTRIES) list_next[prev] = list_next[cur];
                    else list_head = list_next[cur];
                    list_next[cur] = free_head;
                    free_head = cur;
                    if (occupancy > 0) occupancy--;
                    res.slot = 6'(cur);
                end
            end
            MODE_REINIT: begin
                rebuild_chain();
            end
            default: ;
        endcase
        if (occupancy > peak_occupancy) peak_occupancy = occupancy;
        res.count = 7'(occupancy);
        return res;
    endfunction

    // Presents one operation and records its expected result once it is accepted.
    task automatic issue(input mode_t md, input logic signed [31:0] k, input logic [31:0] p,
                         input bit typed, input outcome_t want);
        outcome_t predicted;
        @(negedge aclk);
        while (!quiet && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= md;
        s_key     <= k;
        s_payload <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_list_op(md, k, p);
        pending_results.push_back(typed ? want : predicted);
        issued++;
    endtask

    function automatic logic signed [31:0] pick_key();
        if ($urandom_range(99) < 10) return $urandom;
        return key_pool[$urandom_range(KEY_POOL - 1)];
    endfunction

    function automatic mode_t pick_mode(input int profile);
        int r;
        r = $urandom_range(99);
        case (profile)
            0: return (r < 88) ? MODE_INSERT : (r < 96) ? MODE_DELETE : MODE_COUNT;
            1: return (r < 45) ? MODE_INSERT : (r < 90) ? MODE_DELETE :
                      (r < 98) ? MODE_COUNT : MODE_REINIT;
            default: return (r < 20) ? MODE_INSERT : (r < 93) ? MODE_DELETE :
                            (r < 99) ? MODE_COUNT : MODE_REINIT;
        endcase
    endfunction

    always @(negedge aclk) begin
        m_ready <= quiet || ($urandom_range(99) >= 19);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("sorted_static_linked_list_core_tb: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        outcome_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d slot=%0d count=%0d",
                         $time, m_status, m_slot, m_count);
                errors++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_status !== exp_res.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, exp_res.status, m_status);
                    errors++;
                end
                if (m_slot !== exp_res.slot) begin
                    $display("%0t: slot mismatch, expected %0d, actual %0d",
                             $time, exp_res.slot, m_slot);
                    errors++;
                end
                if (m_count !== exp_res.count) begin
                    $display("%0t: count mismatch, expected %0d, actual %0d",
                             $time, exp_res.count, m_count);
                    errors++;
                end
                case (exp_res.status)
                    ST_FULL:    n_full++;
                    ST_DUP:     n_dup++;
                    ST_MISSING: n_missing++;
                    default: ;
                endcase
            end
        end
    end

    initial begin
        outcome_t no_typed;
        mode_t    md;
        no_typed = '{ST_OK, 6'd0, 7'd0};
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_mode    = MODE_COUNT;
        s_key     = '0;
        s_payload = '0;
        quiet     = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            list_key[i] = '0;
            list_pay[i] = '0;
        end
        rebuild_chain();
        peak_occupancy = 0;

        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7fff_ffff;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        for (int i = 4; i < KEY_POOL; i++) begin
            // Half the pool is clustered near zero so neighbors interleave in the list.
            key_pool[i] = (i % 2) ? $urandom : 32'($urandom_range(200)) - 32'sd100;
        end

        plan.push_back('{MODE_COUNT,  32'sd0, 32'd0, 1'b1, '{ST_OK, 6'd0, 7'd0}});
        plan.push_back('{MODE_DELETE, 32'sd5, 32'd0, 1'b1, '{ST_MISSING, 6'd0, 7'd0}});
        plan.push_back('{MODE_INSERT, 32'sh8000_0000, 32'h0000_0000, 1'b1,
                         '{ST_OK, 6'd0, 7'd1}});
        plan.push_back('{MODE_INSERT, 32'sh7fff_ffff, 32'hffff_ffff, 1'b1,
                         '{ST_OK, 6'd1, 7'd2}});
        plan.push_back('{MODE_INSERT, 32'sh8000_0000, 32'h1234_5678, 1'b1,
                         '{ST_DUP, 6'd0, 7'd2}});
        plan.push_back('{MODE_INSERT, 32'sd0,  32'h5555_5555, 1'b0, no_typed});
        plan.push_back('{MODE_INSERT, -32'sd1, 32'haaaa_aaaa, 1'b0, no_typed});
        plan.push_back('{MODE_INSERT, 32'sd1,  32'h0f0f_0f0f, 1'b0, no_typed});
        plan.push_back('{MODE_DELETE, 32'sd0,  32'h0, 1'b0, no_typed});
        plan.push_back('{MODE_INSERT, 32'sd100, 32'hf0f0_f0f0, 1'b0, no_typed});
        plan.push_back('{MODE_DELETE, 32'sd7,  32'h0, 1'b0, no_typed});
        plan.push_back('{MODE_DELETE, 32'sh7fff_ffff, 32'h0, 1'b0, no_typed});
        plan.push_back('{MODE_DELETE, 32'sh8000_0000, 32'h0, 1'b0, no_typed});
        plan.push_back('{MODE_COUNT,  32'sd0,  32'h0, 1'b0, no_typed});
        plan.push_back('{MODE_REINIT, -32'sd1, 32'hffff_ffff, 1'b1, '{ST_OK, 6'd0, 7'd0}});
        plan.push_back('{MODE_COUNT,  32'sd0,  32'h0, 1'b1, '{ST_OK, 6'd0, 7'd0}});
        plan.push_back('{MODE_INSERT, 32'sd42, 32'h0000_002a, 1'b1, '{ST_OK, 6'd0, 7'd1}});
        plan.push_back('{MODE_DELETE, 32'sd42, 32'h0, 1'b1, '{ST_OK, 6'd0, 7'd0}});
        plan.push_back('{MODE_DELETE, 32'sd42, 32'h0, 1'b1, '{ST_MISSING, 6'd0, 7'd0}});

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            issue(plan[i].mode, plan[i].key, plan[i].payload, plan[i].typed, plan[i].want);
        end

        // Blocks alternate between filling, mixed traffic and draining, so the list
        // runs through full and empty many times. Two blocks run without any stalls.
        for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
            quiet = (blk == 7 || blk == 8);
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                md = pick_mode(blk % 3);
                issue(md, pick_key(), $urandom, 1'b0, no_typed);
            end
        end
        quiet = 1'b0;

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Ran %0d operations; list reached %0d of %0d entries.",
                 issued, peak_occupancy, ENTRIES);
        $display("Rejections seen: %0d full, %0d duplicate key, %0d key not found.",
                 n_full, n_dup, n_missing);
        if (errors == 0) begin
            $display("sorted_static_linked_list_core_tb: clean");
        end else begin
            $display("sorted_static_linked_list_core_tb: errors");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/sll_pkg.sv
sv/sll_ram.sv
sv/sll_engine.sv
sv/sorted_static_linked_list_core.sv
tb/sorted_static_linked_list_core_tb.sv
